// ===== src/obcd_pkg.sv =====
`default_nettype none
package obcd_pkg;
    localparam int NUM_OPS = 5;
    localparam int HISTORY_DEPTH = 4096;
    localparam int OP_W = 3;
    localparam int CNT_W = 13;
    localparam int THR_W = 24;
    localparam int HIDX_W = $clog2(HISTORY_DEPTH);
    localparam int OPS_W = $clog2(NUM_OPS);
    localparam int MEM_DEPTH = NUM_OPS * HISTORY_DEPTH;
    localparam int MEM_AW = $clog2(MEM_DEPTH);
    localparam int ACC_W = 40;
    localparam int NUM_W = 30;
    localparam int DIV_STEPS = NUM_W;
    localparam int DIV_CW = $clog2(DIV_STEPS + 1);
    localparam logic [CNT_W-1:0] WINDOW_RESET = CNT_W'(50);
    localparam logic [THR_W-1:0] THRESH_RESET = THR_W'(196608);
    localparam logic [0:0] REG_WINDOW = 1'b0;
    localparam logic [0:0] REG_THRESH = 1'b1;

    typedef struct packed {
        logic load;
        logic clear_test;
        logic mem_rd;
        logic step;
        logic div_start;
        logic fire;
    } cmd_t;

    typedef struct packed {
        logic valid_op;
        logic test_run;
        logic last_k;
        logic in_prefix;
        logic div_done;
        logic hit;
    } stat_t;
endpackage
`default_nettype wire

// ===== src/obcd_ram.sv =====
`default_nettype none
module obcd_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== src/obcd_ctrl.sv =====
`default_nettype none
module obcd_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    output obcd_pkg::cmd_t      cmd,
    input  wire obcd_pkg::stat_t st
);
    typedef enum logic [2:0] {
        S_IDLE, S_UPD, S_RD, S_WAIT, S_DIV, S_OUT
    } state_t;

    state_t state_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        cmd = '0;
        cmd.load       = in_valid && in_ready;
        cmd.clear_test = (state_reg == S_UPD);
        cmd.mem_rd     = (state_reg == S_RD);
        cmd.div_start  = (state_reg == S_WAIT) && !st.in_prefix;
        cmd.step       = ((state_reg == S_WAIT) && st.in_prefix)
                         || ((state_reg == S_DIV) && st.div_done);
        cmd.fire       = (state_reg == S_DIV) && st.div_done && st.hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE: if (in_valid) state_reg <= S_UPD;
                S_UPD:  state_reg <= (st.valid_op && st.test_run) ? S_RD : S_OUT;
                S_RD:   state_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (!st.in_prefix)
                        state_reg <= S_DIV;
                    else
                        state_reg <= S_RD;
                end
                S_DIV:
                begin
                    if (st.div_done)
                        state_reg <= (st.hit || st.last_k) ? S_OUT : S_RD;
                end
                S_OUT:  if (out_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== src/obcd_dp.sv =====
`default_nettype none
module obcd_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [0:0]                    cfg_idx,
    input  wire logic [obcd_pkg::THR_W-1:0]    cfg_data,
    input  wire logic [obcd_pkg::OP_W-1:0]     op_index,
    input  wire logic                          improved,
    input  wire obcd_pkg::cmd_t                cmd,
    output obcd_pkg::stat_t                    st,
    output logic [obcd_pkg::CNT_W-1:0]         success_count,
    output logic [obcd_pkg::CNT_W-1:0]         failure_count,
    output logic [obcd_pkg::CNT_W-1:0]         history_len,
    output logic                               change_detected,
    output logic                               history_full
);
    localparam int CW = obcd_pkg::CNT_W;
    localparam int AW = obcd_pkg::ACC_W;
    localparam int NW = obcd_pkg::NUM_W;

    logic [CW-1:0] window_reg;
    logic [obcd_pkg::THR_W-1:0] thresh_reg;
    logic [CW-1:0] alpha_reg [obcd_pkg::NUM_OPS];
    logic [CW-1:0] beta_reg  [obcd_pkg::NUM_OPS];
    logic [CW-1:0] use_reg   [obcd_pkg::NUM_OPS];
    logic [obcd_pkg::OPS_W-1:0] op_reg;
    logic valid_reg, full_reg, fired_reg;
    logic [CW-1:0] n_reg, k_reg, w_reg, ones_reg;
    logic [AW-1:0] gp_reg, gm_reg;
    logic [NW-1:0] quot_reg, rem_reg, num_reg;
    logic [obcd_pkg::DIV_CW-1:0] dcnt_reg;
    logic div_busy_reg;
    logic rbit;

    logic [obcd_pkg::OPS_W-1:0] op_in;
    logic [CW-1:0] cur_use;
    logic in_full, in_valid_op;
    logic [CW-1:0] w_eff;
    logic [obcd_pkg::MEM_AW-1:0] waddr, raddr;
    logic [CW-1:0] ones_next;
    logic [NW:0] rem_try;
    logic [NW-1:0] rem_sh;
    logic [AW-1:0] x_val, m_val, gp_sum, gm_sum, gp_next, gm_next;

    assign op_in = op_index[obcd_pkg::OPS_W-1:0];
    assign in_valid_op = (32'(op_index) < obcd_pkg::NUM_OPS);
    assign cur_use = in_valid_op ? use_reg[op_in] : '0;
    assign in_full = (32'(cur_use) >= obcd_pkg::HISTORY_DEPTH);
    assign w_eff = (window_reg == '0) ? CW'(1) : window_reg;

    assign waddr = obcd_pkg::MEM_AW'(32'(op_in) * obcd_pkg::HISTORY_DEPTH
                   + 32'(cur_use));
    assign raddr = obcd_pkg::MEM_AW'(32'(op_reg) * obcd_pkg::HISTORY_DEPTH
                   + 32'(k_reg));

    obcd_ram #(.WIDTH(1), .DEPTH(obcd_pkg::MEM_DEPTH)) u_hist (
        .clk   (clk),
        .we    (cmd.load && in_valid_op && !in_full),
        .waddr (waddr),
        .wdata (improved),
        .raddr (raddr),
        .rdata (rbit)
    );

    // The test walks k from 0; indices below w-1 only build the ones count.
    assign ones_next = ones_reg + CW'(rbit);
    assign rem_sh  = {rem_reg[NW-2:0], num_reg[NW-1]};
    assign rem_try = {1'b0, rem_sh} - (NW+1)'(k_reg + CW'(1));
    assign x_val = rbit ? AW'(65536) : '0;
    assign m_val = AW'(quot_reg);
    assign gp_sum = gp_reg + x_val;
    assign gm_sum = gm_reg + m_val;
    assign gp_next = (gp_sum > m_val) ? gp_sum - m_val : '0;
    assign gm_next = (gm_sum > x_val) ? gm_sum - x_val : '0;

    assign st.valid_op  = valid_reg;
    // Decided while the test registers are still being loaded, so it reads their sources.
    assign st.test_run  = (w_eff <= use_reg[op_reg]);
    assign st.last_k    = (k_reg + CW'(1) == n_reg);
    assign st.in_prefix = (k_reg + CW'(1) < w_reg);
    assign st.div_done  = div_busy_reg && (dcnt_reg == '0);
    assign st.hit = (gp_next >= AW'(thresh_reg)) || (gm_next >= AW'(thresh_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= obcd_pkg::WINDOW_RESET;
            thresh_reg <= obcd_pkg::THRESH_RESET;
            div_busy_reg <= 1'b0;
            for (int i = 0; i < obcd_pkg::NUM_OPS; i++)
            begin
                alpha_reg[i] <= CW'(1);
                beta_reg[i]  <= CW'(1);
                use_reg[i]   <= '0;
            end
        end
        else
        begin
            if (cfg_we && cfg_idx == obcd_pkg::REG_WINDOW)
                window_reg <= cfg_data[CW-1:0];
            if (cfg_we && cfg_idx == obcd_pkg::REG_THRESH)
                thresh_reg <= cfg_data;
            if (cmd.load && in_valid_op && !in_full)
            begin
                use_reg[op_in] <= cur_use + CW'(1);
                if (improved)
                    alpha_reg[op_in] <= alpha_reg[op_in] + CW'(1);
                else
                    beta_reg[op_in] <= beta_reg[op_in] + CW'(1);
            end
            if (cmd.fire)
            begin
                alpha_reg[op_reg] <= CW'(1);
                beta_reg[op_reg]  <= CW'(1);
                use_reg[op_reg]   <= '0;
            end
            if (cmd.div_start)
                div_busy_reg <= 1'b1;
            else if (st.div_done)
                div_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op_in;
            valid_reg <= in_valid_op;
            full_reg  <= in_valid_op && in_full;
            fired_reg <= 1'b0;
        end
        if (cmd.clear_test)
        begin
            n_reg    <= use_reg[op_reg];
            w_reg    <= w_eff;
            k_reg    <= '0;
            ones_reg <= '0;
            gp_reg   <= '0;
            gm_reg   <= '0;
        end
        // Restoring division: (ones*65536 + (k+1)/2) / (k+1), one quotient bit a cycle.
        if (cmd.div_start)
        begin
            ones_reg <= ones_next;
            num_reg  <= NW'({ones_next, 16'h0000})
                        + NW'((k_reg + CW'(1)) >> 1);
            rem_reg  <= '0;
            quot_reg <= '0;
            dcnt_reg <= obcd_pkg::DIV_CW'(obcd_pkg::DIV_STEPS);
        end
        else if (div_busy_reg && dcnt_reg != '0)
        begin
            num_reg  <= {num_reg[NW-2:0], 1'b0};
            if (!rem_try[NW])
                rem_reg <= rem_try[NW-1:0];
            else
                rem_reg <= rem_sh;
            quot_reg <= {quot_reg[NW-2:0], !rem_try[NW]};
            dcnt_reg <= dcnt_reg - 1'b1;
        end
        if (cmd.step)
        begin
            k_reg <= k_reg + CW'(1);
            if (st.in_prefix && !div_busy_reg)
                ones_reg <= ones_next;
            else
            begin
                gp_reg <= gp_next;
                gm_reg <= gm_next;
            end
        end
        if (cmd.fire)
            fired_reg <= 1'b1;
    end

    always_comb
    begin
        if (valid_reg)
        begin
            success_count = alpha_reg[op_reg];
            failure_count = beta_reg[op_reg];
            history_len   = use_reg[op_reg];
        end
        else
        begin
            success_count = '0;
            failure_count = '0;
            history_len   = '0;
        end
        change_detected = valid_reg && fired_reg;
        history_full    = full_reg;
    end
endmodule
`default_nettype wire

// ===== src/operator_bandit_change_detect.sv =====
// An input goes via an update state to the result when the change test does not run; else
// W - 1 prefix steps (window W), each a history read and a wait state, then S <= L - W + 1
// test steps (history length L), each a read, a wait state, a 30-bit restoring divide and a
// done check. One item at a time; a new input is taken the cycle after the result transfer.
// Reset (rst_n, asynchronous, active low): counts to 1, lengths to 0, registers to their
// defaults; the history memory is not cleared and needs no clearing pass.
`default_nettype none
module operator_bandit_change_detect (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_idx,
    input  wire logic [23:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  op_index,
    input  wire logic        improved,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [12:0]      success_count,
    output logic [12:0]      failure_count,
    output logic [12:0]      history_len,
    output logic             change_detected,
    output logic             history_full
);
    obcd_pkg::cmd_t  cmd;
    obcd_pkg::stat_t st;

    obcd_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .st(st)
    );

    obcd_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
        .cfg_data(cfg_data), .op_index(op_index), .improved(improved),
        .cmd(cmd), .st(st), .success_count(success_count),
        .failure_count(failure_count), .history_len(history_len),
        .change_detected(change_detected), .history_full(history_full)
    );
endmodule
`default_nettype wire

// ===== src/obcd_checker.sv =====
`default_nettype none
module obcd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [12:0] history_len,
    input wire logic        change_detected,
    input wire logic        history_full
);
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready while result pending");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_fire: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && change_detected |-> history_len == 13'd0)
        else $error("fired without clearing");
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && history_full && !change_detected |-> history_len == 13'd4096)
        else $error("full flag with short history");
endmodule

bind operator_bandit_change_detect obcd_checker u_chk (.*);
`default_nettype wire
